// ----- rtl/event_flag_group_with_waiters_top_macros.svh -----
// Assertion macros for the event flag group engine.
`ifndef EVENT_FLAG_GROUP_WITH_WAITERS_TOP_MACROS_SVH
`define EVENT_FLAG_GROUP_WITH_WAITERS_TOP_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define EFG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define EFG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/efg_pkg.sv -----
package efg_pkg;
  localparam int FlagWidth = 32;
  localparam int MaxWaiters = 8;
  localparam int TaskIdWidth = 8;
  localparam int SlotWidth = $clog2(MaxWaiters);
  localparam int CountWidth = $clog2(MaxWaiters + 1);
  localparam int ResultWidth = 32;

  typedef enum logic [2:0] {
    MODE_SET = 3'd0,
    MODE_CLEAR = 3'd1,
    MODE_WAIT = 3'd2,
    MODE_READ = 3'd3,
    MODE_WITHDRAW = 3'd4
  } mode_t;

  localparam logic [1:0] KIND_REPLY = 2'd0;
  localparam logic [1:0] KIND_RELEASED = 2'd1;
  localparam logic [1:0] KIND_WITHDRAWN = 2'd2;

  localparam logic [2:0] ST_DONE = 3'd0;
  localparam logic [2:0] ST_SATISFIED = 3'd1;
  localparam logic [2:0] ST_UNMATCHED = 3'd2;
  localparam logic [2:0] ST_QUEUED = 3'd3;
  localparam logic [2:0] ST_FULL = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;
  localparam logic [2:0] ST_ZERO_MASK = 3'd6;

  // Classified request handed from the front end to the engine.
  typedef struct packed {
    logic [2:0] mode;
    logic [FlagWidth-1:0] bits;
    logic [TaskIdWidth-1:0] task_id;
    logic all;
    logic coe;
    logic block;
  } req_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [ResultWidth-1:0] bits;
    logic [TaskIdWidth-1:0] task_ref;
    logic [2:0] status;
    logic last;
  } rsp_t;

  function automatic logic bits_match(input logic [FlagWidth-1:0] word,
                                      input logic [FlagWidth-1:0] mask,
                                      input logic all);
    logic r;
    if (mask == '0) r = 1'b0;
    else if (all) r = ((word & mask) == mask);
    else r = ((word & mask) != '0);
    return r;
  endfunction
endpackage

// ----- rtl/efg_front.sv -----
// Input side: two-entry queue of requests, with mode normalization on entry.
module efg_front (
  input  logic clk,
  input  logic rst_n,
  input  logic in_push,
  output logic in_full,
  input  efg_pkg::req_t in_req,
  output logic req_valid,
  output efg_pkg::req_t req,
  input  logic req_take
);
  efg_pkg::req_t q_r [2];
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic rd_r;
  logic wr_en;
  efg_pkg::req_t norm;

  always_comb begin
    norm = in_req;
    // Unused mode codes behave as a read.
    if (in_req.mode > 3'(efg_pkg::MODE_WITHDRAW)) norm.mode = 3'(efg_pkg::MODE_READ);
  end

  assign in_full = (cnt_r == 2'd2);
  assign wr_en = in_push && !in_full;
  assign req_valid = (cnt_r != 2'd0);
  assign req = q_r[rd_r];
  assign cnt_nxt = cnt_r + 2'(wr_en) - 2'(req_take && req_valid);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (req_take && req_valid) rd_r <= !rd_r;
    end
    if (wr_en) q_r[rd_r ^ (cnt_r != 2'd0) ? 1'b1 : 1'b0] <= norm;
  end
endmodule

// ----- rtl/efg_engine.sv -----
// Back end: carries out one request at a time; a set walks the arrival list.
module efg_engine (
  input  logic clk,
  input  logic rst_n,
  input  logic req_valid,
  input  efg_pkg::req_t req,
  output logic req_take,
  output logic out_empty,
  input  logic out_pop,
  output efg_pkg::rsp_t rsp
);
  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN, S_OUT} state_t;
  localparam int SW = efg_pkg::SlotWidth;
  localparam int CW = efg_pkg::CountWidth;
  localparam int FW = efg_pkg::FlagWidth;

  typedef struct packed {
    logic [FW-1:0] mask;
    logic [efg_pkg::TaskIdWidth-1:0] id;
    logic all;
    logic coe;
  } entry_t;

  state_t state_r;
  logic [FW-1:0] flag_r;
  logic [efg_pkg::MaxWaiters-1:0] valid_r;
  entry_t tab_r [efg_pkg::MaxWaiters];
  logic [SW-1:0] ord_r [efg_pkg::MaxWaiters];
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] idx_r;
  logic [CW-1:0] kept_r;
  logic [FW-1:0] post_r;
  logic [FW-1:0] clr_r;
  efg_pkg::req_t cur_r;
  efg_pkg::rsp_t rsp_r;
  logic have_r;

  logic [SW-1:0] free_slot;
  logic free_ok;
  logic [SW-1:0] scan_slot;
  logic scan_hit;
  logic [SW-1:0] wd_pos;
  logic wd_ok;

  always_comb begin
    free_slot = '0;
    free_ok = 1'b0;
    for (int i = efg_pkg::MaxWaiters - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_slot = SW'(i);
        free_ok = 1'b1;
      end
    end
    wd_pos = '0;
    wd_ok = 1'b0;
    for (int i = efg_pkg::MaxWaiters - 1; i >= 0; i--) begin
      if (CW'(i) < cnt_r && valid_r[ord_r[i]] && tab_r[ord_r[i]].id == req.task_id) begin
        wd_pos = SW'(i);
        wd_ok = 1'b1;
      end
    end
  end

  assign scan_slot = ord_r[idx_r[SW-1:0]];
  assign scan_hit = valid_r[scan_slot] &&
                    efg_pkg::bits_match(post_r, tab_r[scan_slot].mask, tab_r[scan_slot].all);
  // A new request is taken only once the result register is free or being emptied.
  assign req_take = (state_r == S_IDLE) && req_valid && (!have_r || out_pop);
  assign out_empty = !have_r;
  assign rsp = rsp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      flag_r <= '0;
      valid_r <= '0;
      cnt_r <= '0;
      have_r <= 1'b0;
    end else begin
      if (have_r && out_pop) have_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (req_take) begin
            cur_r <= req;
            rsp_r.kind <= efg_pkg::KIND_REPLY;
            rsp_r.task_ref <= req.task_id;
            rsp_r.last <= 1'b1;
            rsp_r.status <= efg_pkg::ST_DONE;
            rsp_r.bits <= '0;
            state_r <= S_OUT;
            unique case (req.mode)
              3'(efg_pkg::MODE_SET): begin
                flag_r <= flag_r | req.bits;
                post_r <= flag_r | req.bits;
                clr_r <= '0;
                idx_r <= '0;
                kept_r <= '0;
                state_r <= S_SCAN;
              end
              3'(efg_pkg::MODE_CLEAR): begin
                flag_r <= flag_r & ~req.bits;
                rsp_r.bits <= flag_r & ~req.bits;
              end
              3'(efg_pkg::MODE_WAIT): begin
                if (req.bits == '0) begin
                  rsp_r.status <= efg_pkg::ST_ZERO_MASK;
                end else if (efg_pkg::bits_match(flag_r, req.bits, req.all)) begin
                  rsp_r.status <= efg_pkg::ST_SATISFIED;
                  rsp_r.bits <= flag_r;
                  if (req.coe) flag_r <= flag_r & ~req.bits;
                end else if (!req.block) begin
                  rsp_r.status <= efg_pkg::ST_UNMATCHED;
                end else if (!free_ok ||
                             cnt_r >= CW'(efg_pkg::MaxWaiters)) begin
                  rsp_r.status <= efg_pkg::ST_FULL;
                end else begin
                  valid_r[free_slot] <= 1'b1;
                  tab_r[free_slot] <= '{req.bits, req.task_id, req.all, req.coe};
                  ord_r[cnt_r[SW-1:0]] <= free_slot;
                  cnt_r <= cnt_r + 1'b1;
                  rsp_r.status <= efg_pkg::ST_QUEUED;
                end
              end
              3'(efg_pkg::MODE_WITHDRAW): begin
                if (wd_ok) begin
                  valid_r[ord_r[wd_pos]] <= 1'b0;
                  for (int j = 0; j < efg_pkg::MaxWaiters - 1; j++) begin
                    if (SW'(j) >= wd_pos) ord_r[j] <= ord_r[j+1];
                  end
                  cnt_r <= cnt_r - 1'b1;
                  rsp_r.kind <= efg_pkg::KIND_WITHDRAWN;
                end else begin
                  rsp_r.status <= efg_pkg::ST_NOT_FOUND;
                end
              end
              default: rsp_r.bits <= flag_r;
            endcase
          end
        end
        S_SCAN: begin
          // One arrival-order position per cycle; a release waits for space.
          if (idx_r >= cnt_r) begin
            cnt_r <= kept_r;
            state_r <= S_FIN;
          end else if (scan_hit) begin
            if (!have_r || out_pop) begin
              have_r <= 1'b1;
              rsp_r <= '{efg_pkg::KIND_RELEASED, post_r, tab_r[scan_slot].id,
                         efg_pkg::ST_SATISFIED, 1'b0};
              valid_r[scan_slot] <= 1'b0;
              if (tab_r[scan_slot].coe) clr_r <= clr_r | tab_r[scan_slot].mask;
              idx_r <= idx_r + 1'b1;
            end
          end else begin
            ord_r[kept_r[SW-1:0]] <= scan_slot;
            kept_r <= kept_r + 1'b1;
            idx_r <= idx_r + 1'b1;
          end
        end
        S_FIN: begin
          if (!have_r || out_pop) begin
            flag_r <= flag_r & ~clr_r;
            have_r <= 1'b1;
            rsp_r <= '{efg_pkg::KIND_REPLY, flag_r & ~clr_r, cur_r.task_id,
                       efg_pkg::ST_DONE, 1'b1};
            state_r <= S_IDLE;
          end
        end
        S_OUT: begin
          if (!have_r || out_pop) begin
            have_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`include "event_flag_group_with_waiters_top_macros.svh"
  `EFG_ASSERT_IMP(a_cnt_range, 1'b1, cnt_r <= CW'(efg_pkg::MaxWaiters), "waiter count overflow")
  `EFG_ASSERT_IMP(a_take_idle, req_take, state_r == S_IDLE, "request taken while busy")
  `EFG_ASSERT_NXT(a_hold, have_r && !out_pop, have_r && $stable(rsp_r), "result lost")
  `EFG_ASSERT_IMP(a_valid_cnt, state_r == S_IDLE, $countones(valid_r) == 32'(cnt_r),
                  "valid bits disagree with count")
endmodule

// ----- rtl/event_flag_group_with_waiters_top.sv -----
// Channel   Ports                       Handshake
// input     in_mode .. in_may_block     accepted on in_push && !in_full
// result    out_kind .. out_last        accepted on out_pop && !out_empty
// A request waits in a two-entry queue, then the engine runs it: clear, read,
// wait and withdraw pass through the output state, and a set scans the
// queued waiters in arrival order and then finishes.
// Reset (rst_n low, synchronous) clears the flag word and the waiter table.
// A result that is not popped stalls the engine; the input queue still fills.
module event_flag_group_with_waiters_top (
  input  logic clk,
  input  logic rst_n,
  input  logic in_push,
  output logic in_full,
  input  logic [2:0] in_mode,
  input  logic [31:0] in_event_bits,
  input  logic [7:0] in_task_id,
  input  logic in_wait_all,
  input  logic in_clear_on_exit,
  input  logic in_may_block,
  output logic out_empty,
  input  logic out_pop,
  output logic [1:0] out_kind,
  output logic [31:0] out_result_bits,
  output logic [7:0] out_task_ref,
  output logic [2:0] out_status,
  output logic out_last
);
  efg_pkg::req_t in_req;
  efg_pkg::req_t req;
  efg_pkg::rsp_t rsp;
  logic req_valid;
  logic req_take;

  assign in_req = '{in_mode, in_event_bits, in_task_id, in_wait_all,
                    in_clear_on_exit, in_may_block};

  efg_front u_front (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
    .in_req(in_req), .req_valid(req_valid), .req(req), .req_take(req_take)
  );

  efg_engine u_engine (
    .clk(clk), .rst_n(rst_n), .req_valid(req_valid), .req(req),
    .req_take(req_take), .out_empty(out_empty), .out_pop(out_pop), .rsp(rsp)
  );

  assign out_kind = rsp.kind;
  assign out_result_bits = rsp.bits;
  assign out_task_ref = rsp.task_ref;
  assign out_status = rsp.status;
  assign out_last = rsp.last;
endmodule

// ----- dv/efg_checker.sv -----
module efg_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic        in_full,
  input  logic [2:0]  in_mode,
  input  logic [31:0] in_event_bits,
  input  logic [7:0]  in_task_id,
  input  logic        in_wait_all,
  input  logic        in_clear_on_exit,
  input  logic        in_may_block,
  input  logic        out_empty,
  input  logic        out_pop,
  input  logic [1:0]  out_kind,
  input  logic [31:0] out_result_bits,
  input  logic [7:0]  out_task_ref,
  input  logic [2:0]  out_status,
  input  logic        out_last,
  output int          fail_count,
  output int          pending_results,
  output int          results_seen,
  output int          releases_seen
);
  typedef struct {
    logic        valid;
    logic [31:0] mask;
    logic [7:0]  id;
    logic        all;
    logic        coe;
  } waiter_entry_t;

  efg_pkg::rsp_t expected_q[$];
  logic [31:0]   flags;
  waiter_entry_t waiters[efg_pkg::MaxWaiters];
  int            order[$];

  function automatic logic flags_satisfy(logic [31:0] word, logic [31:0] mask, logic all);
    if (mask == '0) return 1'b0;
    if (all) return (word & mask) == mask;
    return (word & mask) != '0;
  endfunction

  function automatic efg_pkg::rsp_t make_rsp(logic [1:0] k, logic [31:0] b, logic [7:0] t,
                                             logic [2:0] s, logic l);
    efg_pkg::rsp_t r;
    r.kind = k;
    r.bits = b;
    r.task_ref = t;
    r.status = s;
    r.last = l;
    return r;
  endfunction

  // Applies one request to the local flag group and queues its results.
  task automatic apply_request(logic [2:0] mode, logic [31:0] bits, logic [7:0] id,
                               logic all, logic coe, logic blk);
    logic [31:0] post;
    logic [31:0] clr;
    int          kept[$];
    int          s;
    int          slot;
    int          pos;
    clr = '0;
    slot = -1;
    pos = -1;
    case (mode)
      efg_pkg::MODE_SET: begin
        flags = flags | bits;
        post = flags;
        foreach (order[i]) begin
          s = order[i];
          if (waiters[s].valid && flags_satisfy(post, waiters[s].mask, waiters[s].all)) begin
            if (waiters[s].coe) clr |= waiters[s].mask;
            expected_q.push_back(make_rsp(efg_pkg::KIND_RELEASED, post, waiters[s].id,
                                          efg_pkg::ST_SATISFIED, 1'b0));
            waiters[s].valid = 1'b0;
          end else begin
            kept.push_back(s);
          end
        end
        order = kept;
        flags &= ~clr;
        expected_q.push_back(make_rsp(efg_pkg::KIND_REPLY, flags, id, efg_pkg::ST_DONE, 1'b1));
      end
      efg_pkg::MODE_CLEAR: begin
        flags &= ~bits;
        expected_q.push_back(make_rsp(efg_pkg::KIND_REPLY, flags, id, efg_pkg::ST_DONE, 1'b1));
      end
      efg_pkg::MODE_WAIT: begin
        if (bits == '0) begin
          expected_q.push_back(make_rsp(efg_pkg::KIND_REPLY, '0, id,
                                        efg_pkg::ST_ZERO_MASK, 1'b1));
        end else if (flags_satisfy(flags, bits, all)) begin
          expected_q.push_back(make_rsp(efg_pkg::KIND_REPLY, flags, id,
                                        efg_pkg::ST_SATISFIED, 1'b1));
          if (coe) flags &= ~bits;
        end else if (!blk) begin
          expected_q.push_back(make_rsp(efg_pkg::KIND_REPLY, '0, id,
                                        efg_pkg::ST_UNMATCHED, 1'b1));
        end else begin
          for (int i = efg_pkg::MaxWaiters - 1; i >= 0; i--)
            if (!waiters[i].valid) slot = i;
          if (slot < 0 || order.size() >= efg_pkg::MaxWaiters) begin
            expected_q.push_back(make_rsp(efg_pkg::KIND_REPLY, '0, id,
                                          efg_pkg::ST_FULL, 1'b1));
          end else begin
            waiters[slot] = '{1'b1, bits, id, all, coe};
            order.push_back(slot);
            expected_q.push_back(make_rsp(efg_pkg::KIND_REPLY, '0, id,
                                          efg_pkg::ST_QUEUED, 1'b1));
          end
        end
      end
      efg_pkg::MODE_WITHDRAW: begin
        foreach (order[i]) begin
          if (pos < 0 && waiters[order[i]].valid && waiters[order[i]].id == id) pos = i;
        end
        if (pos >= 0) begin
          waiters[order[pos]].valid = 1'b0;
          order.delete(pos);
          expected_q.push_back(make_rsp(efg_pkg::KIND_WITHDRAWN, '0, id,
                                        efg_pkg::ST_DONE, 1'b1));
        end else begin
          expected_q.push_back(make_rsp(efg_pkg::KIND_REPLY, '0, id,
                                        efg_pkg::ST_NOT_FOUND, 1'b1));
        end
      end
      default: begin
        expected_q.push_back(make_rsp(efg_pkg::KIND_REPLY, flags, id, efg_pkg::ST_DONE, 1'b1));
      end
    endcase
  endtask

  // Predictions made after a pop in the same edge never serve that pop, so order is safe.
  always @(posedge clk) begin
    efg_pkg::rsp_t want;
    if (!rst_n) begin
      flags = '0;
      foreach (waiters[i]) waiters[i] = '{1'b0, '0, '0, 1'b0, 1'b0};
      order.delete();
      expected_q.delete();
      fail_count = 0;
      results_seen = 0;
      releases_seen = 0;
    end else begin
      if (out_pop && !out_empty) begin
        results_seen++;
        if (out_kind == efg_pkg::KIND_RELEASED) releases_seen++;
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: kind %0d bits %h task %0d status %0d last %0d",
                     out_kind, out_result_bits, out_task_ref, out_status, out_last);
        end else begin
          want = expected_q.pop_front();
          if (out_kind !== want.kind || out_result_bits !== want.bits ||
              out_task_ref !== want.task_ref || out_status !== want.status ||
              out_last !== want.last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected kind %0d bits %h task %0d status %0d last %0d,",
                       want.kind, want.bits, want.task_ref, want.status, want.last,
                       " got kind %0d bits %h task %0d status %0d last %0d",
                       out_kind, out_result_bits, out_task_ref, out_status, out_last);
          end
        end
      end
      if (in_push && !in_full)
        apply_request(in_mode, in_event_bits, in_task_id, in_wait_all,
                      in_clear_on_exit, in_may_block);
    end
    pending_results = expected_q.size();
  end
endmodule

// ----- dv/tb_top.sv -----
module tb_top;
  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [2:0]  in_mode;
  logic [31:0] in_event_bits;
  logic [7:0]  in_task_id;
  logic        in_wait_all;
  logic        in_clear_on_exit;
  logic        in_may_block;
  logic        out_empty;
  logic        out_pop;
  logic [1:0]  out_kind;
  logic [31:0] out_result_bits;
  logic [7:0]  out_task_ref;
  logic [2:0]  out_status;
  logic        out_last;
  int          fail_count;
  int          pending_results;
  int          results_seen;
  int          releases_seen;
  int          requests_sent;
  logic        hold_off;
  logic        stimulus_done;

  event_flag_group_with_waiters_top dut (.*);

  efg_checker checker_inst (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("timeout");
    $display("event_flag_group_with_waiters_top regression: fail");
    $finish;
  end

  // Offers one transaction at the falling edge and holds it until accepted.
  task automatic send_request(logic [2:0] mode, logic [31:0] bits, logic [7:0] id,
                              logic all, logic coe, logic blk);
    @(negedge clk);
    in_push <= 1'b1;
    in_mode <= mode;
    in_event_bits <= bits;
    in_task_id <= id;
    in_wait_all <= all;
    in_clear_on_exit <= coe;
    in_may_block <= blk;
    @(posedge clk);
    while (in_full) @(posedge clk);
    requests_sent++;
  endtask

  task automatic idle_input(int cycles);
    @(negedge clk);
    in_push <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_bits();
    case ($urandom_range(0, 5))
      0: return 32'h1 << $urandom_range(0, 31);
      1: return $urandom() & 32'hF;
      2: return $urandom() & $urandom();
      3: return '0;
      4: return '1;
      default: return $urandom();
    endcase
  endfunction

  // The receiver stalls in its own pattern; hold_off forces a long stretch.
  always @(negedge clk) begin
    if (!rst_n || hold_off) out_pop <= 1'b0;
    else if (stimulus_done) out_pop <= ($urandom_range(0, 3) != 0);
    else out_pop <= ($urandom_range(0, 9) < 6) || ($urandom_range(0, 1) == 1);
  end

  initial begin
    int burst;
    int tail;
    logic [2:0] m;
    logic [31:0] b;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_mode = efg_pkg::MODE_READ;
    in_event_bits = '0;
    in_task_id = '0;
    in_wait_all = 1'b0;
    in_clear_on_exit = 1'b0;
    in_may_block = 1'b0;
    hold_off = 1'b0;
    stimulus_done = 1'b0;
    requests_sent = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part: every mode, every wait outcome, table full, duplicates.
    send_request(efg_pkg::MODE_READ, '0, 8'd0, 1'b0, 1'b0, 1'b0);
    send_request(efg_pkg::MODE_WAIT, '0, 8'd1, 1'b1, 1'b1, 1'b1);
    send_request(efg_pkg::MODE_WAIT, 32'h3, 8'd2, 1'b0, 1'b0, 1'b0);
    for (int i = 0; i < efg_pkg::MaxWaiters; i++)
      send_request(efg_pkg::MODE_WAIT, 32'h1 << i, (i == 1) ? 8'd255 : 8'd3 + i[7:0],
                   i[0], i[1], 1'b1);
    send_request(efg_pkg::MODE_WAIT, 32'h8000_0000, 8'd255, 1'b1, 1'b0, 1'b1);
    send_request(efg_pkg::MODE_WITHDRAW, '0, 8'd255, 1'b0, 1'b0, 1'b0);
    send_request(efg_pkg::MODE_WITHDRAW, '0, 8'd200, 1'b0, 1'b0, 1'b0);
    send_request(efg_pkg::MODE_SET, 32'h0000_00F5, 8'd9, 1'b0, 1'b0, 1'b0);
    send_request(efg_pkg::MODE_SET, 32'hFFFF_FFFF, 8'd255, 1'b1, 1'b1, 1'b1);
    send_request(efg_pkg::MODE_WAIT, 32'hF0F0_0000, 8'd4, 1'b1, 1'b1, 1'b0);
    send_request(efg_pkg::MODE_WAIT, 32'h0000_0003, 8'd5, 1'b0, 1'b0, 1'b1);
    send_request(efg_pkg::MODE_CLEAR, 32'hFFFF_FFFF, 8'd6, 1'b0, 1'b0, 1'b0);
    send_request(3'd5, '0, 8'd7, 1'b0, 1'b0, 1'b0);
    send_request(3'd6, '0, 8'd8, 1'b1, 1'b1, 1'b1);
    send_request(3'd7, '0, 8'd0, 1'b0, 1'b0, 1'b0);

    // Long receiver hold-off while the sender keeps pushing.
    fork
      begin
        hold_off <= 1'b1;
        repeat (150) @(posedge clk);
        hold_off <= 1'b0;
      end
      for (int i = 0; i < 12; i++)
        send_request(efg_pkg::MODE_WAIT, 32'h1 << $urandom_range(0, 7),
                     8'($urandom_range(0, 15)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1);
    join

    // Random part: mostly waits and sets on a small task and bit set, mixed with clears, withdraws and reads.
    while (requests_sent < 250) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst; i++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: m = efg_pkg::MODE_SET;
          3, 4, 5: m = efg_pkg::MODE_WAIT;
          6: m = efg_pkg::MODE_CLEAR;
          7: m = efg_pkg::MODE_WITHDRAW;
          8: m = efg_pkg::MODE_READ;
          default: m = 3'($urandom_range(0, 7));
        endcase
        b = (m == efg_pkg::MODE_SET || m == efg_pkg::MODE_WAIT) && $urandom_range(0, 3) != 0
            ? 32'h1 << $urandom_range(0, 7) | ($urandom() & 32'h0F)
            : pick_bits();
        send_request(m, b,
                     $urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(0, 7)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     $urandom_range(0, 4) != 0);
      end
      if ($urandom_range(0, 2) != 0) idle_input($urandom_range(1, 20));
    end
    idle_input(0);
    stimulus_done = 1'b1;

    tail = 0;
    while (pending_results != 0 && tail < 20000) begin
      @(posedge clk);
      tail++;
    end
    repeat (40) @(posedge clk);
    $display("sent %0d requests, checked %0d results including %0d waiter releases",
             requests_sent, results_seen, releases_seen);
    if (fail_count == 0 && pending_results == 0)
      $display("event_flag_group_with_waiters_top regression: pass");
    else
      $display("event_flag_group_with_waiters_top regression: fail");
    $finish;
  end
endmodule
